### hw/rtl/depth_pixel_backprojection_top_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef DEPTH_PIXEL_BACKPROJECTION_TOP_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_TOP_MACROS_SVH

// same-cycle implication
`define DPB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dpb: same-cycle check failed");

// next-cycle implication
`define DPB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dpb: next-cycle check failed");

`endif

### hw/rtl/dpb_pkg.sv
package dpb_pkg;

  localparam int unsigned PIX_W      = 12;
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned CTR_W      = 16;
  localparam int unsigned RECIP_W    = 32;
  localparam int unsigned Z_W        = 32;
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned PROD_W     = MAG_W + Z_W;
  localparam int unsigned PT_W       = 48;
  localparam int unsigned NUM_STAGES = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 152;

  localparam logic [RECIP_W-1:0] INV_DEPTH_RST = 32'd858993;
  localparam logic [CTR_W-1:0]   CENTER_COL_RST = 16'd5112;
  localparam logic [CTR_W-1:0]   CENTER_ROW_RST = 16'd3832;
  localparam logic [RECIP_W-1:0] INV_FOCAL_RST  = 32'd8180890;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_DEPTH     = 3'd0,
    CFG_CENTER_COL    = 3'd1,
    CFG_CENTER_ROW    = 3'd2,
    CFG_INV_FOCAL_COL = 3'd3,
    CFG_INV_FOCAL_ROW = 3'd4
  } cfg_idx_e;

  // fields that ride alongside the arithmetic
  typedef struct packed {
    logic               nz;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } side_t;

endpackage

### hw/rtl/depth_pixel_backprojection_top.sv
// Back-projects one depth-camera pixel per word to a 3-D point through a pinhole model:
// z = raw_depth * inv_depth_scale >> 16 (Q16.16), x and y = |u*16 - center| * z *
// inv_focal >> 36 with the offset's sign, saturated to 48 bits; color passes through
// and point_valid (tuser) is low for a raw depth of zero, which gives zero coordinates.
// The pipeline has five register stages, and a new word can be taken every cycle while
// the output is not stalled; the stages hold the three cascaded multiplies (depth scale,
// then offset times z, then the reciprocal focal length split into two half-width
// products and summed) and a final saturation stage. Stalls from the output side
// propagate back combinationally through the enable chain, so bubbles fill before the
// input is held off. Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the
// user must write them only while no word is in flight, as the block does not enforce
// it. Indexes beyond the register list are ignored. No state needs clearing after reset.
`include "depth_pixel_backprojection_top_macros.svh"

module depth_pixel_backprojection_top #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pixel_col, pixel_row, raw_depth, red_in, green_in, blue_in
  input  logic [dpb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // point_x, point_y, point_z, red_out, green_out, blue_out
  output logic [dpb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // point_valid
  output logic [0:0]                          m_axis_tuser
);

  localparam int unsigned LAST = dpb_pkg::NUM_STAGES - 1;

  logic [dpb_pkg::RECIP_W-1:0] inv_depth_q, inv_focal_col_q, inv_focal_row_q;
  logic [dpb_pkg::CTR_W-1:0]   center_col_q, center_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_depth_q     <= dpb_pkg::INV_DEPTH_RST;
      center_col_q    <= dpb_pkg::CENTER_COL_RST;
      center_row_q    <= dpb_pkg::CENTER_ROW_RST;
      inv_focal_col_q <= dpb_pkg::INV_FOCAL_RST;
      inv_focal_row_q <= dpb_pkg::INV_FOCAL_RST;
    end else if (cfg_we_i) begin
      case (dpb_pkg::cfg_idx_e'(cfg_idx_i))
        dpb_pkg::CFG_INV_DEPTH:     inv_depth_q     <= cfg_data_i;
        dpb_pkg::CFG_CENTER_COL:    center_col_q    <= cfg_data_i[dpb_pkg::CTR_W-1:0];
        dpb_pkg::CFG_CENTER_ROW:    center_row_q    <= cfg_data_i[dpb_pkg::CTR_W-1:0];
        dpb_pkg::CFG_INV_FOCAL_COL: inv_focal_col_q <= cfg_data_i;
        dpb_pkg::CFG_INV_FOCAL_ROW: inv_focal_row_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [dpb_pkg::PIX_W-1:0]   in_col, in_row;
  logic [dpb_pkg::DEPTH_W-1:0] in_depth;
  dpb_pkg::side_t              in_side;

  assign in_col   = s_axis_tdata[11:0];
  assign in_row   = s_axis_tdata[23:12];
  assign in_depth = s_axis_tdata[39:24];
  assign in_side  = '{nz:    (in_depth != '0),
                      red:   s_axis_tdata[47:40],
                      green: s_axis_tdata[55:48],
                      blue:  s_axis_tdata[63:56]};

  logic [dpb_pkg::NUM_STAGES-1:0] vld_q, en;

  always_comb begin
    en[LAST] = !vld_q[LAST] || m_axis_tready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < dpb_pkg::NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  dpb_pkg::side_t          side_q [dpb_pkg::NUM_STAGES];
  logic [dpb_pkg::Z_W-1:0] z_q    [1:LAST];
  logic [dpb_pkg::Z_W-1:0] z0;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= in_side;
    end
    if (en[1]) begin
      z_q[1] <= z0;
    end
    for (int k = 1; k < dpb_pkg::NUM_STAGES; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
    for (int k = 2; k < dpb_pkg::NUM_STAGES; k++) begin
      if (en[k]) begin
        z_q[k] <= z_q[k-1];
      end
    end
  end

  logic [dpb_pkg::PROD_W-1:0] prod_x, prod_y;
  logic                       neg_x, neg_y;
  logic [dpb_pkg::PT_W-1:0]   point_x, point_y;
  logic [dpb_pkg::Z_W-1:0]    point_z;

  dpb_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .en_i         (en[1:0]),
    .col_i        (in_col),
    .row_i        (in_row),
    .depth_i      (in_depth),
    .inv_depth_i  (inv_depth_q),
    .center_col_i (center_col_q),
    .center_row_i (center_row_q),
    .z_o          (z0),
    .prod_x_o     (prod_x),
    .prod_y_o     (prod_y),
    .neg_x_o      (neg_x),
    .neg_y_o      (neg_y)
  );

  dpb_lat u_lat_x (
    .clk_i       (clk_i),
    .en_i        (en[4:2]),
    .prod_i      (prod_x),
    .neg_i       (neg_x),
    .inv_focal_i (inv_focal_col_q),
    .point_o     (point_x)
  );

  dpb_lat u_lat_y (
    .clk_i       (clk_i),
    .en_i        (en[4:2]),
    .prod_i      (prod_y),
    .neg_i       (neg_y),
    .inv_focal_i (inv_focal_row_q),
    .point_o     (point_y)
  );

  assign point_z       = z_q[LAST];
  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[LAST];
  assign m_axis_tdata  = {side_q[LAST].blue, side_q[LAST].green, side_q[LAST].red,
                          point_z, point_y, point_x};
  assign m_axis_tuser  = side_q[LAST].nz;

  `DPB_ASSERT_IMP(a_ready_when_empty, !vld_q[0], s_axis_tready)
  `DPB_ASSERT_NXT(a_accept_fills, s_axis_tvalid && s_axis_tready, vld_q[0])
  `DPB_ASSERT_IMP(a_zero_z_no_lateral, m_axis_tvalid && (point_z == '0), (point_x == '0) && (point_y == '0))
  `DPB_ASSERT_IMP(a_invalid_zero_z, m_axis_tvalid && !m_axis_tuser[0], point_z == '0)

endmodule

### hw/rtl/dpb_front.sv
module dpb_front #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                              clk_i,
  input  logic [1:0]                        en_i,
  input  logic [dpb_pkg::PIX_W-1:0]         col_i,
  input  logic [dpb_pkg::PIX_W-1:0]         row_i,
  input  logic [dpb_pkg::DEPTH_W-1:0]       depth_i,
  input  logic [dpb_pkg::RECIP_W-1:0]       inv_depth_i,
  input  logic [dpb_pkg::CTR_W-1:0]         center_col_i,
  input  logic [dpb_pkg::CTR_W-1:0]         center_row_i,
  output logic [dpb_pkg::Z_W-1:0]           z_o,
  output logic [dpb_pkg::PROD_W-1:0]        prod_x_o,
  output logic [dpb_pkg::PROD_W-1:0]        prod_y_o,
  output logic                              neg_x_o,
  output logic                              neg_y_o
);

  localparam int unsigned ZP_W = dpb_pkg::DEPTH_W + dpb_pkg::RECIP_W;
  localparam logic [dpb_pkg::PIX_W-1:0] CMASK = (COORD_BITS >= dpb_pkg::PIX_W) ?
      {dpb_pkg::PIX_W{1'b1}} : dpb_pkg::PIX_W'((32'd1 << COORD_BITS) - 32'd1);

  // {sign, magnitude} of coord*16 - center
  function automatic logic [dpb_pkg::MAG_W:0] offset_mag(
    input logic [dpb_pkg::PIX_W-1:0] c,
    input logic [dpb_pkg::CTR_W-1:0] ctr
  );
    logic [dpb_pkg::CTR_W-1:0] c16;
    c16 = dpb_pkg::CTR_W'({c, 4'b0000});
    if (c16 < ctr) begin
      return {1'b1, dpb_pkg::MAG_W'(ctr - c16)};
    end else begin
      return {1'b0, dpb_pkg::MAG_W'(c16 - ctr)};
    end
  endfunction

  logic [ZP_W-1:0]               zp;
  logic [dpb_pkg::MAG_W:0]       off_x, off_y;
  logic [dpb_pkg::Z_W-1:0]       z_q;
  logic [dpb_pkg::MAG_W-1:0]     mag_x_q, mag_y_q;
  logic                          neg_x_q, neg_y_q;
  logic [dpb_pkg::PROD_W-1:0]    prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  logic                          neg_x2_q, neg_y2_q;

  assign zp    = ZP_W'(depth_i) * ZP_W'(inv_depth_i);
  assign off_x = offset_mag(col_i & CMASK, center_col_i);
  assign off_y = offset_mag(row_i & CMASK, center_row_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      z_q     <= zp[ZP_W-1:ZP_W-dpb_pkg::Z_W];
      neg_x_q <= off_x[dpb_pkg::MAG_W];
      mag_x_q <= off_x[dpb_pkg::MAG_W-1:0];
      neg_y_q <= off_y[dpb_pkg::MAG_W];
      mag_y_q <= off_y[dpb_pkg::MAG_W-1:0];
    end
  end

  assign prod_x_d = dpb_pkg::PROD_W'(mag_x_q) * dpb_pkg::PROD_W'(z_q);
  assign prod_y_d = dpb_pkg::PROD_W'(mag_y_q) * dpb_pkg::PROD_W'(z_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      neg_x2_q <= neg_x_q;
      neg_y2_q <= neg_y_q;
    end
  end

  assign z_o      = z_q;
  assign prod_x_o = prod_x_q;
  assign prod_y_o = prod_y_q;
  assign neg_x_o  = neg_x2_q;
  assign neg_y_o  = neg_y2_q;

endmodule

### hw/rtl/dpb_lat.sv
module dpb_lat (
  input  logic                             clk_i,
  input  logic [2:0]                       en_i,
  input  logic [dpb_pkg::PROD_W-1:0]       prod_i,
  input  logic                             neg_i,
  input  logic [dpb_pkg::RECIP_W-1:0]      inv_focal_i,
  output logic [dpb_pkg::PT_W-1:0]         point_o
);

  localparam int unsigned LO_W  = dpb_pkg::PROD_W / 2;
  localparam int unsigned HI_W  = dpb_pkg::PROD_W - LO_W;
  localparam int unsigned PLO_W = LO_W + dpb_pkg::RECIP_W;
  localparam int unsigned PHI_W = HI_W + dpb_pkg::RECIP_W;
  localparam int unsigned SUM_W = dpb_pkg::PROD_W + dpb_pkg::RECIP_W;
  localparam int unsigned SHIFT = 36;
  localparam int unsigned Q_W   = SUM_W - SHIFT;
  localparam int unsigned QE_W  = dpb_pkg::PT_W + 1;
  localparam logic [QE_W-1:0] POS_LIM = {2'b00, {(dpb_pkg::PT_W-1){1'b1}}};
  localparam logic [QE_W-1:0] NEG_LIM = {2'b01, {(dpb_pkg::PT_W-1){1'b0}}};

  logic [PLO_W-1:0]           pp_lo_d, pp_lo_q;
  logic [PHI_W-1:0]           pp_hi_d, pp_hi_q;
  logic                       neg3_q, neg4_q;
  logic [SUM_W-1:0]           sum;
  logic [Q_W-1:0]             q_q;
  logic [QE_W-1:0]            qe, lim, sat;
  logic [dpb_pkg::PT_W-1:0]   mag, point_d, point_q;

  // split product, each half under 32x32
  assign pp_lo_d = PLO_W'(prod_i[LO_W-1:0]) * PLO_W'(inv_focal_i);
  assign pp_hi_d = PHI_W'(prod_i[dpb_pkg::PROD_W-1:LO_W]) * PHI_W'(inv_focal_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d;
      neg3_q  <= neg_i;
    end
  end

  assign sum = SUM_W'({pp_hi_q, {LO_W{1'b0}}}) + SUM_W'(pp_lo_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      q_q    <= sum[SUM_W-1:SHIFT];
      neg4_q <= neg3_q;
    end
  end

  assign qe      = QE_W'(q_q);
  assign lim     = neg4_q ? NEG_LIM : POS_LIM;
  assign sat     = (qe > lim) ? lim : qe;
  assign mag     = sat[dpb_pkg::PT_W-1:0];
  assign point_d = neg4_q ? (~mag + 1'b1) : mag;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      point_q <= point_d;
    end
  end

  assign point_o = point_q;

endmodule
